@@ sv/rbst_pkg.sv @@
// shared constants and word types for the ray versus box slab test
package rbst_pkg;

	// coordinate format, fixed by the word fields
	localparam int CW  = 32;
	localparam int FB  = 16;
	localparam int NAX = 3;

	// slab divider widths
	localparam int NMW = CW + 1;
	localparam int NW  = NMW + FB;
	localparam int QW  = CW - 1;

	// divider latency: input register, one stage per quotient bit, output register
	localparam int DIV_LAT  = QW + 2;
	// lane latency: prep register plus divider
	localparam int LANE_LAT = 1 + DIV_LAT;

	localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0] origin_x;
		logic signed [CW-1:0] origin_y;
		logic signed [CW-1:0] origin_z;
		logic signed [CW-1:0] dir_x;
		logic signed [CW-1:0] dir_y;
		logic signed [CW-1:0] dir_z;
		logic signed [CW-1:0] box_min_x;
		logic signed [CW-1:0] box_min_y;
		logic signed [CW-1:0] box_min_z;
		logic signed [CW-1:0] box_max_x;
		logic signed [CW-1:0] box_max_y;
		logic signed [CW-1:0] box_max_z;
	} in_t;

	typedef struct packed {
		logic                 hit;
		logic [CW-2:0]        entry_t;
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] point_z;
	} out_t;

	// what one axis lane hands to the merge stage
	typedef struct packed {
		logic                 miss;
		logic signed [CW-1:0] tn;
		logic signed [CW-1:0] tf;
		logic signed [CW-1:0] o;
		logic                 dneg;
		logic [CW-1:0]        dmag;
	} lane_t;

endpackage

@@ sv/rbst_div.sv @@
// pipelined restoring divider for one slab distance, one quotient bit per stage
module rbst_div import rbst_pkg::*; (
	input  logic                 clk,
	input  logic [NMW-1:0]       num_mag,
	input  logic [CW-1:0]        den_mag,
	input  logic                 neg,
	output logic signed [CW-1:0] quo
);

	localparam int WW = NW + CW;

	logic [NW-1:0] rem_s [0:QW];
	logic [CW-1:0] den_s [0:QW];
	logic          neg_s [0:QW];
	logic          sat_s [0:QW];
	logic [QW-1:0] q_s   [0:QW];

	logic [NW-1:0] num_sh;
	logic          sat_in;

	// scaled numerator and saturation check against den shifted to the sign bit
	assign num_sh = {num_mag, {FB{1'b0}}};
	assign sat_in = ({{CW{1'b0}}, num_sh} >= ({{NW{1'b0}}, den_mag} << (CW - 1)));

	always_ff @(posedge clk) begin
		rem_s[0] <= num_sh;
		den_s[0] <= den_mag;
		neg_s[0] <= neg;
		sat_s[0] <= sat_in;
		q_s[0]   <= '0;
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int SH = QW - 1 - k;
		logic [WW-1:0] dsh;
		logic [WW-1:0] rext;
		logic [WW-1:0] diff;
		logic          ge;
		logic [QW-1:0] qn;

		assign dsh  = {{NW{1'b0}}, den_s[k]} << SH;
		assign rext = {{CW{1'b0}}, rem_s[k]};
		assign ge   = (rext >= dsh);
		assign diff = rext - dsh;
		assign qn   = q_s[k] | ({{(QW-1){1'b0}}, ge} << SH);

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[NW-1:0] : rem_s[k];
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			sat_s[k+1] <= sat_s[k];
			q_s[k+1]   <= qn;
		end
	end

	// apply sign and saturation
	always_ff @(posedge clk) begin
		if (sat_s[QW]) begin
			quo <= neg_s[QW] ? MINV : MAXV;
		end else if (neg_s[QW]) begin
			quo <= -$signed({1'b0, q_s[QW]});
		end else begin
			quo <= $signed({1'b0, q_s[QW]});
		end
	end

endmodule

@@ sv/rbst_lane.sv @@
// one axis lane: near and far bound selection and the two slab divisions
module rbst_lane import rbst_pkg::*; (
	input  logic                 clk,
	input  logic signed [CW-1:0] o,
	input  logic signed [CW-1:0] d,
	input  logic signed [CW-1:0] lo,
	input  logic signed [CW-1:0] hi,
	output lane_t                lane
);

	logic                 dz, dneg, zmiss, negn, negf;
	logic signed [CW-1:0] nb, fb;
	logic signed [CW:0]   diffn, difff;
	logic [NMW-1:0]       magn, magf;
	logic [CW-1:0]        dmag;

	logic [NMW-1:0]       magn_s1, magf_s1;
	logic                 negn_s1, negf_s1, dz_s1, zmiss_s1, dneg_s1;
	logic [CW-1:0]        dmag_s1;
	logic signed [CW-1:0] o_s1;

	logic                 dz_q    [0:DIV_LAT-1];
	logic                 zmiss_q [0:DIV_LAT-1];
	logic                 dneg_q  [0:DIV_LAT-1];
	logic [CW-1:0]        dmag_q  [0:DIV_LAT-1];
	logic signed [CW-1:0] o_q     [0:DIV_LAT-1];

	logic signed [CW-1:0] tn, tf;

	// bound selection by direction sign and signed differences
	always_comb begin
		dz    = (d == '0);
		dneg  = d[CW-1];
		nb    = dneg ? hi : lo;
		fb    = dneg ? lo : hi;
		diffn = {nb[CW-1], nb} - {o[CW-1], o};
		difff = {fb[CW-1], fb} - {o[CW-1], o};
		magn  = diffn[CW] ? NMW'(-diffn) : NMW'(diffn);
		magf  = difff[CW] ? NMW'(-difff) : NMW'(difff);
		negn  = diffn[CW] ^ dneg;
		negf  = difff[CW] ^ dneg;
		dmag  = dneg ? CW'(-d) : CW'(d);
		zmiss = dz && ((o < lo) || (o > hi));
	end

	always_ff @(posedge clk) begin
		magn_s1  <= magn;
		magf_s1  <= magf;
		negn_s1  <= negn;
		negf_s1  <= negf;
		dz_s1    <= dz;
		zmiss_s1 <= zmiss;
		dneg_s1  <= dneg;
		dmag_s1  <= dmag;
		o_s1     <= o;
	end

	rbst_div u_div_near (
		.clk     (clk),
		.num_mag (magn_s1),
		.den_mag (dmag_s1),
		.neg     (negn_s1),
		.quo     (tn)
	);

	rbst_div u_div_far (
		.clk     (clk),
		.num_mag (magf_s1),
		.den_mag (dmag_s1),
		.neg     (negf_s1),
		.quo     (tf)
	);

	// side data delay line matching the divider
	always_ff @(posedge clk) begin
		dz_q[0]    <= dz_s1;
		zmiss_q[0] <= zmiss_s1;
		dneg_q[0]  <= dneg_s1;
		dmag_q[0]  <= dmag_s1;
		o_q[0]     <= o_s1;
		for (int i = 1; i < DIV_LAT; i++) begin
			dz_q[i]    <= dz_q[i-1];
			zmiss_q[i] <= zmiss_q[i-1];
			dneg_q[i]  <= dneg_q[i-1];
			dmag_q[i]  <= dmag_q[i-1];
			o_q[i]     <= o_q[i-1];
		end
	end

	// a zero direction leaves entry and exit untouched
	always_comb begin
		lane.miss = zmiss_q[DIV_LAT-1];
		lane.tn   = dz_q[DIV_LAT-1] ? '0 : tn;
		lane.tf   = dz_q[DIV_LAT-1] ? MAXV : tf;
		lane.o    = o_q[DIV_LAT-1];
		lane.dneg = dneg_q[DIV_LAT-1];
		lane.dmag = dmag_q[DIV_LAT-1];
	end

endmodule

@@ sv/rbst_merge.sv @@
// merge of the three lanes: entry and exit, hit decision and entry point
module rbst_merge import rbst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid,
	input  lane_t lanes [NAX],
	output logic  done,
	output out_t  result
);

	localparam int PW = 2 * CW - 1;
	localparam int SW = 2 * CW + 1;

	logic signed [CW-1:0] entry, exitp;
	logic                 miss;

	logic                 v_s1, v_s2;
	logic signed [CW-1:0] entry_s1, exit_s1;
	logic                 miss_s1;
	logic signed [CW-1:0] o_s1 [NAX];
	logic                 dneg_s1 [NAX];
	logic [CW-1:0]        dmag_s1 [NAX];

	logic                 hit_s2;
	logic [CW-2:0]        entry_s2;
	logic signed [CW-1:0] o_s2 [NAX];
	logic                 dneg_s2 [NAX];
	logic [PW-1:0]        prod_s2 [NAX];

	logic signed [CW-1:0] pt [NAX];

	// maximum of near distances and minimum of far distances
	always_comb begin
		entry = '0;
		exitp = MAXV;
		miss  = 1'b0;
		for (int a = 0; a < NAX; a++) begin
			if (lanes[a].tn > entry) begin
				entry = lanes[a].tn;
			end
			if (lanes[a].tf < exitp) begin
				exitp = lanes[a].tf;
			end
			miss = miss | lanes[a].miss;
		end
	end

	always_ff @(posedge clk) begin
		entry_s1 <= entry;
		exit_s1  <= exitp;
		miss_s1  <= miss;
		for (int a = 0; a < NAX; a++) begin
			o_s1[a]    <= lanes[a].o;
			dneg_s1[a] <= lanes[a].dneg;
			dmag_s1[a] <= lanes[a].dmag;
		end
	end

	// hit decision and entry times direction magnitude
	always_ff @(posedge clk) begin
		hit_s2   <= !miss_s1 && (entry_s1 <= exit_s1);
		entry_s2 <= entry_s1[CW-2:0];
		for (int a = 0; a < NAX; a++) begin
			o_s2[a]    <= o_s1[a];
			dneg_s2[a] <= dneg_s1[a];
			prod_s2[a] <= PW'(entry_s1[CW-2:0]) * PW'(dmag_s1[a]);
		end
	end

	// offset the origin and saturate
	always_comb begin
		for (int a = 0; a < NAX; a++) begin
			logic [PW-1:0]        p;
			logic signed [SW-1:0] s;
			p = prod_s2[a] >> FB;
			s = dneg_s2[a] ? (SW'(o_s2[a]) - $signed(SW'(p)))
			               : (SW'(o_s2[a]) + $signed(SW'(p)));
			if (s > SW'(MAXV)) begin
				pt[a] = MAXV;
			end else if (s < SW'(MINV)) begin
				pt[a] = MINV;
			end else begin
				pt[a] = s[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		result.hit     <= hit_s2;
		result.entry_t <= hit_s2 ? entry_s2 : '0;
		result.point_x <= hit_s2 ? pt[0] : '0;
		result.point_y <= hit_s2 ? pt[1] : '0;
		result.point_z <= hit_s2 ? pt[2] : '0;
	end

	// word valid through the merge stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

endmodule

@@ sv/ray_box_slab_test.sv @@
// top level of the ray versus axis-aligned box slab test
//
// Takes one word per clock: busy never rises, so every start is accepted. Each
// word comes back on result with done high for one cycle, in the order taken,
// after the prep register, a divider with one quotient bit per stage, and
// three merge stages. Three axis lanes each run a near and a far divider side
// by side; the merge takes the largest entry and the smallest exit, then forms
// the entry point with one multiplier per axis.
// The receiver has no way to stall, so done must be sampled every cycle.
module ray_box_slab_test import rbst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic done,
	output out_t result
);

	logic  vld_q [0:LANE_LAT-1];
	lane_t lanes [NAX];

	assign busy = 1'b0;

	// word valid alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= start && !busy;
			for (int i = 1; i < LANE_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	rbst_lane u_lane_x (
		.clk  (clk),
		.o    (item.origin_x),
		.d    (item.dir_x),
		.lo   (item.box_min_x),
		.hi   (item.box_max_x),
		.lane (lanes[0])
	);

	rbst_lane u_lane_y (
		.clk  (clk),
		.o    (item.origin_y),
		.d    (item.dir_y),
		.lo   (item.box_min_y),
		.hi   (item.box_max_y),
		.lane (lanes[1])
	);

	rbst_lane u_lane_z (
		.clk  (clk),
		.o    (item.origin_z),
		.d    (item.dir_z),
		.lo   (item.box_min_z),
		.hi   (item.box_max_z),
		.lane (lanes[2])
	);

	rbst_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (vld_q[LANE_LAT-1]),
		.lanes  (lanes),
		.done   (done),
		.result (result)
	);

endmodule
